// ----- sv/pms_pkg.sv -----
package pms_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_PITCH_BYTE  = 3'd0;
    localparam logic [2:0] OP_LENGTH_BYTE = 3'd1;
    localparam logic [2:0] OP_FREQ_ENTRY  = 3'd2;
    localparam logic [2:0] OP_DUR_ENTRY   = 3'd3;
    localparam logic [2:0] OP_START       = 3'd4;
    localparam logic [2:0] OP_TICK        = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_NOTE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PITCH_BITS   = 2'd1;
    localparam logic [1:0] CFG_LENGTH_BITS  = 2'd2;

    // widths fixed by the register and field formats
    localparam int CFG_DATA_W = 11;
    localparam int POS_W      = 11;
    localparam int WIDTH_W    = 4;
    localparam int MAX_IDX_W  = 8;

    // input item
    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  addr;
        logic [15:0] load_value;
        logic [15:0] elapsed_ms;
    } t_item;

    // result item
    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_hz;
        logic [9:0]  current_note;
    } t_result;

endpackage

// ----- sv/packed_melody_sequencer_unit.sv -----
// packed melody sequencer
// input items are offered on i_item with start; an item is taken at a rising edge
// where start is high and busy is low. load items (pitch byte, length byte,
// frequency entry, duration entry) are written in the accept cycle and leave
// busy low. a start item or a tick item that runs out the note time walks
// the shared unpack unit twice (pitch index, then duration index) through
// one byte read per cycle from the packed stores and one table read, then
// one pass of the shared 34-bit adder:
//   start: both index lookups, then the add step and the result strobe
//   tick: subtract step, then as for start if the note time ran out, else no result
// a new item may be offered in the cycle the result strobe is high.
// each result stays on o_result until the next, marked by o_strobe high for
// a single cycle; the receiver cannot stall it, so nothing is buffered.
// configuration is written on i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// do so only while idle, the block itself does not enforce this.
// reset (i_rst_n low, synchronous) returns to idle with note 0, zero time,
// note count 1 and both index widths 8; stores and tables are not cleared.
module packed_melody_sequencer_unit #(
    parameter int MAX_NOTES     = 1024,
    parameter int TABLE_ENTRIES = 256,
    parameter int PACKED_BYTES  = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pms_pkg::t_item                      i_item,
    output logic                                o_strobe,
    output pms_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [pms_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pms_pkg::*;

    localparam int PB_AW  = (PACKED_BYTES > 1) ? $clog2(PACKED_BYTES) : 1;
    localparam int TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUB  = 3'd1;
    localparam logic [2:0] ST_LO   = 3'd2;
    localparam logic [2:0] ST_HI   = 3'd3;
    localparam logic [2:0] ST_EXT  = 3'd4;
    localparam logic [2:0] ST_TAB  = 3'd5;
    localparam logic [2:0] ST_ADD  = 3'd6;

    // control state
    logic [2:0]           r_state, n_state;
    logic                 r_phase, n_phase;      // 0 pitch index, 1 duration index
    logic [POS_W-1:0]     r_pos, n_pos;
    logic signed [31:0]   r_time, n_time;
    logic [POS_W-1:0]     r_note_count;
    logic [WIDTH_W-1:0]   r_pitch_bits;
    logic [WIDTH_W-1:0]   r_length_bits;
    logic                 r_strobe;

    // payload registers
    logic [15:0]          r_elapsed;
    logic [7:0]           r_lo;
    logic                 r_rd_oor;
    logic                 r_tab_oor;
    logic [15:0]          r_freq;
    logic [15:0]          r_dur;
    t_result              r_result;

    // memories
    logic [7:0]           r_pitch_mem [PACKED_BYTES];
    logic [7:0]           r_length_mem [PACKED_BYTES];
    logic [15:0]          r_freq_mem [TABLE_ENTRIES];
    logic [15:0]          r_dur_mem [TABLE_ENTRIES];
    logic [7:0]           r_pitch_rd;
    logic [7:0]           r_length_rd;
    logic [15:0]          r_freq_rd;
    logic [15:0]          r_dur_rd;

    logic                 accept;
    logic [WIDTH_W-1:0]   w_raw;
    logic [WIDTH_W-1:0]   w_eff;
    logic [14:0]          bit_pos;
    logic [11:0]          byte_lo;
    logic [11:0]          byte_rd;
    logic                 rd_oor;
    logic [7:0]           rd_data;
    logic [7:0]           hi_byte;
    logic [15:0]          pair_shift;
    logic [8:0]           idx_mask;
    logic [7:0]           idx;
    logic [PB_AW-1:0]     store_wa;
    logic [PB_AW-1:0]     store_ra;
    logic                 store_in_range;
    logic                 table_in_range;
    logic [TBL_AW-1:0]    table_wa;
    logic [TBL_AW-1:0]    table_ra;
    logic [POS_W-1:0]     count_eff;
    logic [POS_W:0]       pos_inc;
    logic [POS_W-1:0]     pos_next;
    logic [33:0]          sum;
    logic [31:0]          sum_sat;
    logic                 sum_pos;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // index width of the active phase, clamped to one byte
    assign w_raw = r_phase ? r_length_bits : r_pitch_bits;
    assign w_eff = (w_raw > WIDTH_W'(MAX_IDX_W)) ? WIDTH_W'(MAX_IDX_W) : w_raw;

    // bit and byte address of the active index
    assign bit_pos = 15'(r_pos) * 15'(w_eff);
    assign byte_lo = 12'(bit_pos[14:3]);
    assign byte_rd = (r_state == ST_HI) ? (byte_lo + 12'd1) : byte_lo;
    assign rd_oor  = (32'(byte_rd) >= PACKED_BYTES);
    assign store_ra = PB_AW'(byte_rd);

    // shared unpack unit: shift the byte pair and mask to the index width
    assign rd_data    = r_phase ? r_length_rd : r_pitch_rd;
    assign hi_byte    = r_rd_oor ? 8'd0 : rd_data;
    assign pair_shift = {hi_byte, r_lo} >> bit_pos[2:0];
    assign idx_mask   = (9'd1 << w_eff) - 9'd1;
    assign idx        = pair_shift[7:0] & idx_mask[7:0];
    assign table_ra   = TBL_AW'(idx);

    // load address decode
    assign store_in_range = (32'(i_item.addr) < PACKED_BYTES);
    assign table_in_range = (32'(i_item.addr) < TABLE_ENTRIES);
    assign store_wa       = PB_AW'(i_item.addr);
    assign table_wa       = TBL_AW'(i_item.addr);

    // next note with wrap at the effective count
    always_comb begin
        if (r_note_count == '0) begin
            count_eff = POS_W'(1);
        end else if (32'(r_note_count) > MAX_NOTES) begin
            count_eff = POS_W'(MAX_NOTES);
        end else begin
            count_eff = r_note_count;
        end
    end
    assign pos_inc  = {1'b0, r_pos} + (POS_W+1)'(1);
    assign pos_next = (pos_inc >= {1'b0, count_eff}) ? '0 : pos_inc[POS_W-1:0];

    // shared adder: subtract elapsed time on a tick, add duration otherwise
    assign sum = {{2{r_time[31]}}, r_time}
               + ((r_state == ST_SUB) ? (34'd0 - {18'd0, r_elapsed}) : {18'd0, r_dur});
    always_comb begin
        if (sum[33] && (sum[32:31] != 2'b11)) begin
            sum_sat = 32'h8000_0000;
        end else if (!sum[33] && (sum[32:31] != 2'b00)) begin
            sum_sat = 32'h7fff_ffff;
        end else begin
            sum_sat = sum[31:0];
        end
    end
    assign sum_pos = !sum_sat[31] && (sum_sat != 32'd0);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_time  = r_time;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.op == OP_START)) begin
                    n_pos   = '0;
                    n_time  = '0;
                    n_phase = 1'b0;
                    n_state = ST_LO;
                end else if (accept && (i_item.op == OP_TICK)) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                n_time = $signed(sum_sat);
                if (sum_pos) begin
                    n_state = ST_IDLE;
                end else begin
                    n_pos   = pos_next;
                    n_phase = 1'b0;
                    n_state = ST_LO;
                end
            end
            ST_LO:  n_state = ST_HI;
            ST_HI:  n_state = ST_EXT;
            ST_EXT: n_state = ST_TAB;
            ST_TAB: begin
                if (!r_phase) begin
                    n_phase = 1'b1;
                    n_state = ST_LO;
                end else begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_time  = $signed(sum_sat);
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= 1'b0;
            r_pos         <= '0;
            r_time        <= '0;
            r_strobe      <= 1'b0;
            r_note_count  <= POS_W'(1);
            r_pitch_bits  <= WIDTH_W'(MAX_IDX_W);
            r_length_bits <= WIDTH_W'(MAX_IDX_W);
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_time   <= n_time;
            r_strobe <= (r_state == ST_ADD);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NOTE_COUNT:  r_note_count  <= i_cfg_data;
                    CFG_PITCH_BITS:  r_pitch_bits  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_LENGTH_BITS: r_length_bits <= i_cfg_data[WIDTH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elapsed <= i_item.elapsed_ms;
        end
        if ((r_state == ST_LO) || (r_state == ST_HI)) begin
            r_rd_oor <= rd_oor;
        end
        if (r_state == ST_HI) begin
            r_lo <= r_rd_oor ? 8'd0 : rd_data;
        end
        if (r_state == ST_EXT) begin
            r_tab_oor <= (32'(idx) >= TABLE_ENTRIES);
        end
        if (r_state == ST_TAB) begin
            if (!r_phase) begin
                r_freq <= r_tab_oor ? 16'd0 : r_freq_rd;
            end else begin
                r_dur  <= r_tab_oor ? 16'd0 : r_dur_rd;
            end
        end
        if (r_state == ST_ADD) begin
            r_result.tone_on      <= (r_freq != 16'd0);
            r_result.tone_hz      <= r_freq;
            r_result.current_note <= r_pos[9:0];
        end
    end

    // packed pitch store
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.op == OP_PITCH_BYTE) && store_in_range) begin
            r_pitch_mem[store_wa] <= i_item.load_value[7:0];
        end
        r_pitch_rd <= r_pitch_mem[store_ra];
    end

    // packed length store
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.op == OP_LENGTH_BYTE) && store_in_range) begin
            r_length_mem[store_wa] <= i_item.load_value[7:0];
        end
        r_length_rd <= r_length_mem[store_ra];
    end

    // frequency table
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.op == OP_FREQ_ENTRY) && table_in_range) begin
            r_freq_mem[table_wa] <= i_item.load_value;
        end
        r_freq_rd <= r_freq_mem[table_ra];
    end

    // duration table
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.op == OP_DUR_ENTRY) && table_in_range) begin
            r_dur_mem[table_wa] <= i_item.load_value;
        end
        r_dur_rd <= r_dur_mem[table_ra];
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // a result only follows the final add step
    a_strobe_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ST_ADD))
        else $error("result strobe without a final add step");

    // results are never back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // a start item always makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.op == OP_START)) |=> busy)
        else $error("start item did not begin a note lookup");

    // tone flag agrees with the frequency
    a_tone_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.tone_on == (o_result.tone_hz != 16'd0)))
        else $error("tone flag does not match frequency");

endmodule
